// File: src/sparse_polynomial_adder_macros.svh
// Assertion macros for the sparse polynomial adder.
// Used by the top level only; no other dependencies.
`ifndef SPARSE_POLYNOMIAL_ADDER_MACROS_SVH
`define SPARSE_POLYNOMIAL_ADDER_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define SPA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define SPA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: src/spa_pkg.sv
// Shared types, sizes and command codes for the sparse polynomial adder.
// No dependencies.
package spa_pkg;

  // Capacity of each term store.
  localparam int MAX_TERMS = 32;
  localparam int ADDR_W    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);

  localparam int COEF_W = 32;
  localparam int EXPO_W = 16;
  localparam int SUM_W  = COEF_W + 1;

  // Command codes of an input item.
  localparam logic [1:0] CMD_LOAD_FIRST  = 2'd0;
  localparam logic [1:0] CMD_LOAD_SECOND = 2'd1;
  localparam logic [1:0] CMD_ADD         = 2'd2;

  // One stored term.
  typedef struct packed {
    logic signed [COEF_W-1:0] coef;
    logic [EXPO_W-1:0]        expo;
  } term_t;

  // Which heads the merge unit consumes in one step.
  typedef struct packed {
    logic use_a;
    logic use_b;
  } sel_t;

  // Status of the two store heads, from the sequencer to the merge unit.
  typedef struct packed {
    logic a_valid;
    logic b_valid;
  } head_t;

endpackage

// File: src/spa_term_store.sv
// Term store: a single-port-write, single-port-read memory of terms.
// Depends on spa_pkg for the term type and the depth.
module spa_term_store (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [spa_pkg::ADDR_W-1:0] wr_addr,
  input  spa_pkg::term_t             wr_data,
  input  logic [spa_pkg::ADDR_W-1:0] rd_addr,
  output spa_pkg::term_t             rd_data
);

  spa_pkg::term_t mem [spa_pkg::MAX_TERMS];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: src/spa_merge_unit.sv
// Merge unit: compares the two head exponents and forms one result term.
// Depends on spa_pkg for the term, head and select types.
module spa_merge_unit (
  input  spa_pkg::term_t                  head_a,
  input  spa_pkg::term_t                  head_b,
  input  spa_pkg::head_t                  heads,
  output spa_pkg::sel_t                   sel,
  output logic signed [spa_pkg::SUM_W-1:0] sum_coef,
  output logic [spa_pkg::EXPO_W-1:0]      sum_expo
);

  logic                             a_gt;
  logic                             a_lt;
  logic signed [spa_pkg::SUM_W-1:0] op_a;
  logic signed [spa_pkg::SUM_W-1:0] op_b;

  // Exponent compare decides which heads are consumed.
  assign a_gt = head_a.expo > head_b.expo;
  assign a_lt = head_a.expo < head_b.expo;

  always_comb begin
    sel.use_a = heads.a_valid && (!heads.b_valid || !a_lt);
    sel.use_b = heads.b_valid && (!heads.a_valid || !a_gt);
  end

  // Exact sum of the consumed coefficients.
  assign op_a     = sel.use_a ? spa_pkg::SUM_W'(head_a.coef) : '0;
  assign op_b     = sel.use_b ? spa_pkg::SUM_W'(head_b.coef) : '0;
  assign sum_coef = op_a + op_b;
  assign sum_expo = sel.use_a ? head_a.expo : head_b.expo;

endmodule

// File: src/sparse_polynomial_adder.sv
// Top level of the sparse polynomial adder: sequencer, stores and output register.
// Depends on spa_pkg, spa_term_store, spa_merge_unit and the assertion macros.
//
// Load items (command 0 or 1) are taken one per cycle and append a term to the
// first or second store; a load into a full store of MAX_TERMS terms is dropped
// and raises terms_dropped on the results of the next add. An add item (command
// 2) holds in_stall high while the merged result is emitted, which has at most
// the sum of the two store counts in terms; one merge unit and one read port per
// store produce one term a cycle while out_stall does not hold the output register.
// The add moves the sequencer into its merge state, where the registered store
// reads feed the merge unit, and each merged term is written to the output
// register. An add on two empty stores emits nothing. Command 3 is ignored.
// Loads may follow as soon as the last term sits in the output register.
`include "sparse_polynomial_adder_macros.svh"

module sparse_polynomial_adder (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_command,
  input  logic signed [spa_pkg::COEF_W-1:0]   in_coefficient,
  input  logic [spa_pkg::EXPO_W-1:0]          in_exponent,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [spa_pkg::SUM_W-1:0]    out_sum_coefficient,
  output logic [spa_pkg::EXPO_W-1:0]          out_term_exponent,
  output logic                                out_last_term,
  output logic                                out_terms_dropped
);

  typedef enum logic {ST_IDLE, ST_MERGE} state_t;

  state_t                           state_r, state_nxt;
  logic [spa_pkg::CNT_W-1:0]        cnt_a_r, cnt_a_nxt;
  logic [spa_pkg::CNT_W-1:0]        cnt_b_r, cnt_b_nxt;
  logic [spa_pkg::CNT_W-1:0]        idx_a_r, idx_a_nxt;
  logic [spa_pkg::CNT_W-1:0]        idx_b_r, idx_b_nxt;
  logic                             ovf_r, ovf_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic signed [spa_pkg::SUM_W-1:0] out_coef_r;
  logic [spa_pkg::EXPO_W-1:0]       out_expo_r;
  logic                             out_last_r;
  logic                             out_drop_r;

  logic                             in_acc;
  logic                             step;
  logic                             full_a;
  logic                             full_b;
  logic                             wr_a;
  logic                             wr_b;
  logic                             last;
  logic [spa_pkg::CNT_W-1:0]        idx_a_adv;
  logic [spa_pkg::CNT_W-1:0]        idx_b_adv;
  spa_pkg::term_t                   wr_term;
  spa_pkg::term_t                   head_a;
  spa_pkg::term_t                   head_b;
  spa_pkg::head_t                   heads;
  spa_pkg::sel_t                    sel;
  logic signed [spa_pkg::SUM_W-1:0] sum_coef;
  logic [spa_pkg::EXPO_W-1:0]       sum_expo;

  // Handshake decode.
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign step     = (state_r == ST_MERGE) && (!out_valid_r || !out_stall);

  // Load path into the two stores.
  assign full_a  = cnt_a_r >= spa_pkg::CNT_W'(spa_pkg::MAX_TERMS);
  assign full_b  = cnt_b_r >= spa_pkg::CNT_W'(spa_pkg::MAX_TERMS);
  assign wr_a    = in_acc && (in_command == spa_pkg::CMD_LOAD_FIRST) && !full_a;
  assign wr_b    = in_acc && (in_command == spa_pkg::CMD_LOAD_SECOND) && !full_b;
  assign wr_term = '{coef: in_coefficient, expo: in_exponent};

  spa_term_store u_store_a (
    .clk     (clk),
    .wr_en   (wr_a),
    .wr_addr (cnt_a_r[spa_pkg::ADDR_W-1:0]),
    .wr_data (wr_term),
    .rd_addr (idx_a_nxt[spa_pkg::ADDR_W-1:0]),
    .rd_data (head_a)
  );

  spa_term_store u_store_b (
    .clk     (clk),
    .wr_en   (wr_b),
    .wr_addr (cnt_b_r[spa_pkg::ADDR_W-1:0]),
    .wr_data (wr_term),
    .rd_addr (idx_b_nxt[spa_pkg::ADDR_W-1:0]),
    .rd_data (head_b)
  );

  // Shared merge unit works on the registered heads.
  assign heads.a_valid = idx_a_r < cnt_a_r;
  assign heads.b_valid = idx_b_r < cnt_b_r;

  spa_merge_unit u_merge (
    .head_a   (head_a),
    .head_b   (head_b),
    .heads    (heads),
    .sel      (sel),
    .sum_coef (sum_coef),
    .sum_expo (sum_expo)
  );

  assign idx_a_adv = idx_a_r + spa_pkg::CNT_W'(sel.use_a);
  assign idx_b_adv = idx_b_r + spa_pkg::CNT_W'(sel.use_b);
  assign last      = (idx_a_adv >= cnt_a_r) && (idx_b_adv >= cnt_b_r);

  // Sequencer next-state logic.
  always_comb begin
    state_nxt     = state_r;
    cnt_a_nxt     = cnt_a_r;
    cnt_b_nxt     = cnt_b_r;
    idx_a_nxt     = idx_a_r;
    idx_b_nxt     = idx_b_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        idx_a_nxt = '0;
        idx_b_nxt = '0;
        if (in_acc) begin
          if (wr_a) begin
            cnt_a_nxt = cnt_a_r + 1'b1;
          end
          if (wr_b) begin
            cnt_b_nxt = cnt_b_r + 1'b1;
          end
          if ((in_command == spa_pkg::CMD_LOAD_FIRST && full_a) ||
              (in_command == spa_pkg::CMD_LOAD_SECOND && full_b)) begin
            ovf_nxt = 1'b1;
          end
          if (in_command == spa_pkg::CMD_ADD) begin
            if (cnt_a_r != '0 || cnt_b_r != '0) begin
              state_nxt = ST_MERGE;
            end else begin
              ovf_nxt = 1'b0;
            end
          end
        end
      end
      ST_MERGE: begin
        if (step) begin
          idx_a_nxt     = idx_a_adv;
          idx_b_nxt     = idx_b_adv;
          out_valid_nxt = 1'b1;
          if (last) begin
            state_nxt = ST_IDLE;
            cnt_a_nxt = '0;
            cnt_b_nxt = '0;
            ovf_nxt   = 1'b0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      idx_a_r     <= '0;
      idx_b_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      idx_a_r     <= idx_a_nxt;
      idx_b_r     <= idx_b_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      if (step) begin
        out_coef_r <= sum_coef;
        out_expo_r <= sum_expo;
        out_last_r <= last;
        out_drop_r <= ovf_r;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_sum_coefficient = out_coef_r;
  assign out_term_exponent   = out_expo_r;
  assign out_last_term       = out_last_r;
  assign out_terms_dropped   = out_drop_r;

  // Checks on the sequencer.
  `SPA_ASSERT(a_heads_left, clk, rst_n, (state_r == ST_MERGE) |-> (heads.a_valid || heads.b_valid), "merge running with both stores exhausted")
  `SPA_ASSERT(a_idx_bound, clk, rst_n, (state_r == ST_MERGE) |-> (idx_a_r <= cnt_a_r && idx_b_r <= cnt_b_r), "merge index ran past its store count")
  `SPA_ASSERT(a_end_clear, clk, rst_n, (step && last) |=> (cnt_a_r == '0 && cnt_b_r == '0 && !ovf_r && state_r == ST_IDLE), "stores not emptied after the last term")
  `SPA_ASSERT(a_cnt_cap, clk, rst_n, (cnt_a_r <= spa_pkg::CNT_W'(spa_pkg::MAX_TERMS)) && (cnt_b_r <= spa_pkg::CNT_W'(spa_pkg::MAX_TERMS)), "store count above capacity")

endmodule

// File: dv/tb_sparse_polynomial_adder.sv
`timescale 1ns / 100ps
// Self-checking testbench for sparse_polynomial_adder: loads, merges and ignored commands.
// Depends on spa_pkg and the sparse_polynomial_adder RTL; reads no files.
module tb_sparse_polynomial_adder;

  // Command value that the block ignores.
  localparam logic [1:0] CMD_IGNORED = 2'd3;
  localparam logic signed [spa_pkg::COEF_W-1:0] MIN_COEF =
    {1'b1, {(spa_pkg::COEF_W-1){1'b0}}};
  localparam logic signed [spa_pkg::COEF_W-1:0] MAX_COEF =
    {1'b0, {(spa_pkg::COEF_W-1){1'b1}}};
  localparam int FIRST_STORE    = 0;
  localparam int SECOND_STORE   = 1;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int END_PAUSE      = 20;
  localparam int CHUNK_ITEMS    = 44;

  typedef struct {
    logic [1:0]                        command;
    logic signed [spa_pkg::COEF_W-1:0] coefficient;
    logic [spa_pkg::EXPO_W-1:0]        exponent;
  } poly_item_t;

  typedef struct {
    logic signed [spa_pkg::SUM_W-1:0] sum_coefficient;
    logic [spa_pkg::EXPO_W-1:0]       term_exponent;
    logic                             last_term;
    logic                             terms_dropped;
  } poly_term_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [1:0] in_command = CMD_IGNORED;
  logic signed [spa_pkg::COEF_W-1:0] in_coefficient = '0;
  logic [spa_pkg::EXPO_W-1:0] in_exponent = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  logic signed [spa_pkg::SUM_W-1:0] out_sum_coefficient;
  logic [spa_pkg::EXPO_W-1:0] out_term_exponent;
  logic out_last_term;
  logic out_terms_dropped;

  poly_item_t pending_items[$];
  poly_term_t expected_terms[$];
  int mismatches = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int holds_asked = 0;
  int holds_served = 0;
  int hold_left = 0;
  int idle_cycles = 0;

  // Predicted contents of the two term stores.
  logic signed [spa_pkg::COEF_W-1:0] store_coef [2][spa_pkg::MAX_TERMS];
  logic [spa_pkg::EXPO_W-1:0] store_expo [2][spa_pkg::MAX_TERMS];
  int store_count [2] = '{0, 0};
  logic dropped_seen = 1'b0;

  sparse_polynomial_adder dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_command          (in_command),
    .in_coefficient      (in_coefficient),
    .in_exponent         (in_exponent),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_sum_coefficient (out_sum_coefficient),
    .out_term_exponent   (out_term_exponent),
    .out_last_term       (out_last_term),
    .out_terms_dropped   (out_terms_dropped)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic poly_term_t make_term(input logic signed [spa_pkg::SUM_W-1:0] sum,
                                           input logic [spa_pkg::EXPO_W-1:0] expo);
    poly_term_t t;
    t.sum_coefficient = sum;
    t.term_exponent   = expo;
    t.last_term       = 1'b0;
    t.terms_dropped   = dropped_seen;
    return t;
  endfunction

  function automatic logic signed [spa_pkg::SUM_W-1:0] widen(
    input logic signed [spa_pkg::COEF_W-1:0] c);
    return spa_pkg::SUM_W'(c);
  endfunction

  // Update the predicted stores for one accepted item and queue the terms an add emits.
  task automatic predict_sum_terms(input logic [1:0] cmd,
                                   input logic signed [spa_pkg::COEF_W-1:0] coef,
                                   input logic [spa_pkg::EXPO_W-1:0] expo);
    poly_term_t terms[$];
    int s;
    int i;
    int j;
    i = 0;
    j = 0;
    if (cmd == spa_pkg::CMD_LOAD_FIRST || cmd == spa_pkg::CMD_LOAD_SECOND) begin
      s = (cmd == spa_pkg::CMD_LOAD_SECOND) ? SECOND_STORE : FIRST_STORE;
      if (store_count[s] >= spa_pkg::MAX_TERMS) begin
        dropped_seen = 1'b1;
      end else begin
        store_coef[s][store_count[s]] = coef;
        store_expo[s][store_count[s]] = expo;
        store_count[s]++;
      end
    end else if (cmd == spa_pkg::CMD_ADD) begin
      // Two-way merge on the head exponents, tails copied as they stand.
      while (i < store_count[FIRST_STORE] || j < store_count[SECOND_STORE]) begin
        if (j >= store_count[SECOND_STORE] ||
            (i < store_count[FIRST_STORE] &&
             store_expo[FIRST_STORE][i] > store_expo[SECOND_STORE][j])) begin
          terms.push_back(make_term(widen(store_coef[FIRST_STORE][i]),
                                    store_expo[FIRST_STORE][i]));
          i++;
        end else if (i >= store_count[FIRST_STORE] ||
                     store_expo[FIRST_STORE][i] < store_expo[SECOND_STORE][j]) begin
          terms.push_back(make_term(widen(store_coef[SECOND_STORE][j]),
                                    store_expo[SECOND_STORE][j]));
          j++;
        end else begin
          terms.push_back(make_term(widen(store_coef[FIRST_STORE][i]) +
                                    widen(store_coef[SECOND_STORE][j]),
                                    store_expo[FIRST_STORE][i]));
          i++;
          j++;
        end
      end
      if (terms.size() != 0) terms[terms.size()-1].last_term = 1'b1;
      foreach (terms[k]) expected_terms.push_back(terms[k]);
      store_count[FIRST_STORE]  = 0;
      store_count[SECOND_STORE] = 0;
      dropped_seen = 1'b0;
    end
  endtask

  task automatic check_field(input string field, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Driver: presents the next pending item whenever the current one has been taken.
  always @(posedge clk) begin : driver
    poly_item_t next_item;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_items.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
        next_item = pending_items.pop_front();
        in_valid       <= 1'b1;
        in_command     <= next_item.command;
        in_coefficient <= next_item.coefficient;
        in_exponent    <= next_item.exponent;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: a long hold when asked for, otherwise random stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (holds_served != holds_asked) begin
      out_stall <= 1'b1;
      hold_left = HOLD_CYCLES;
      holds_served = holds_served + 1;
    end else begin
      out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
    end
  end

  // Monitor: predicts from each accepted input item and checks each accepted term.
  always @(posedge clk) begin : monitor
    poly_term_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) predict_sum_terms(in_command, in_coefficient, in_exponent);
      if (out_valid && !out_stall) begin
        if (expected_terms.size() == 0) begin
          $display("%0t: unexpected term, expected none, actual coef %0d exp %0d last %0b",
                   $time, out_sum_coefficient, out_term_exponent, out_last_term);
          mismatches++;
        end else begin
          want = expected_terms.pop_front();
          check_field("sum_coefficient", 64'(want.sum_coefficient),
                      64'(out_sum_coefficient));
          check_field("term_exponent", 64'(want.term_exponent), 64'(out_term_exponent));
          check_field("last_term", 64'(want.last_term), 64'(out_last_term));
          check_field("terms_dropped", 64'(want.terms_dropped), 64'(out_terms_dropped));
        end
      end
    end
  end

  // Watchdog: ends the run when no item moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_item(input logic [1:0] cmd, input logic [spa_pkg::COEF_W-1:0] coef,
                           input logic [spa_pkg::EXPO_W-1:0] expo);
    pending_items.push_back('{cmd, coef, expo});
  endtask

  function automatic logic [spa_pkg::EXPO_W-1:0] random_exponent();
    return spa_pkg::EXPO_W'($urandom);
  endfunction

  function automatic logic signed [spa_pkg::COEF_W-1:0] random_coefficient();
    case ($urandom_range(15, 0))
      0: return MIN_COEF;
      1: return MAX_COEF;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_size();
    int r;
    r = $urandom_range(99, 0);
    if (r < 85) return $urandom_range(5, 0);
    if (r < 96) return $urandom_range(16, 6);
    return $urandom_range(spa_pkg::MAX_TERMS + 3, spa_pkg::MAX_TERMS - 4);
  endfunction

  // Two well-formed polynomials with descending exponents, loaded interleaved, then an add.
  task automatic queue_merge_case(input int n_first, input int n_second);
    poly_item_t first_q[$];
    poly_item_t second_q[$];
    logic signed [spa_pkg::COEF_W-1:0] c;
    int e;
    int step;
    int left;
    int pick;
    left = n_first + n_second;
    e = ($urandom_range(9, 0) == 0) ? 65535 : $urandom_range(65535, left);
    while (first_q.size() < n_first || second_q.size() < n_second) begin
      // 0: first only, 1: second only, 2: matching exponents in both.
      if (first_q.size() == n_first) pick = 1;
      else if (second_q.size() == n_second) pick = 0;
      else pick = $urandom_range(2, 0);
      c = random_coefficient();
      if (pick != 1) first_q.push_back('{spa_pkg::CMD_LOAD_FIRST, c, e[spa_pkg::EXPO_W-1:0]});
      if (pick != 0)
        second_q.push_back('{spa_pkg::CMD_LOAD_SECOND,
                             (pick == 2 && $urandom_range(3, 0) == 0) ? -c : random_coefficient(),
                             e[spa_pkg::EXPO_W-1:0]});
      left = n_first + n_second - first_q.size() - second_q.size();
      step = $urandom_range((e / (left + 1) > 1) ? e / (left + 1) : 1, 1);
      e = (e > step) ? e - step : 0;
    end
    while (first_q.size() != 0 || second_q.size() != 0) begin
      if (second_q.size() == 0 || (first_q.size() != 0 && $urandom_range(1, 0) == 1))
        pending_items.push_back(first_q.pop_front());
      else
        pending_items.push_back(second_q.pop_front());
    end
    push_item(spa_pkg::CMD_ADD, $urandom, random_exponent());
  endtask

  // Mostly well-formed merges; the rest unordered loads, lone adds and ignored commands.
  task automatic queue_random_items(input int budget);
    int placed;
    int before_size;
    int r;
    placed = 0;
    while (placed < budget) begin
      before_size = pending_items.size();
      r = $urandom_range(99, 0);
      if (r < 70) begin
        queue_merge_case(pick_size(), pick_size());
      end else if (r < 80) begin
        repeat ($urandom_range(4, 1))
          push_item($urandom_range(1, 0) ? spa_pkg::CMD_LOAD_SECOND : spa_pkg::CMD_LOAD_FIRST,
                    random_coefficient(), random_exponent());
        if ($urandom_range(1, 0)) push_item(spa_pkg::CMD_ADD, $urandom, random_exponent());
      end else if (r < 86) begin
        // Ignored items do not count toward the budget.
        push_item(CMD_IGNORED, $urandom, random_exponent());
        before_size = pending_items.size();
      end else if (r < 92) begin
        push_item(spa_pkg::CMD_ADD, $urandom, random_exponent());
      end else begin
        push_item($urandom_range(1, 0) ? spa_pkg::CMD_LOAD_SECOND : spa_pkg::CMD_LOAD_FIRST,
                  random_coefficient(), random_exponent());
      end
      placed += pending_items.size() - before_size;
    end
  endtask

  task automatic queue_directed_items();
    // Add on two empty stores, then an ignored command.
    push_item(spa_pkg::CMD_ADD, '0, '0);
    push_item(CMD_IGNORED, '1, '1);
    // Largest and smallest sums, a zero sum and a tail copied from the first store.
    push_item(spa_pkg::CMD_LOAD_FIRST, MAX_COEF, 16'hFFFF);
    push_item(spa_pkg::CMD_LOAD_SECOND, MAX_COEF, 16'hFFFF);
    push_item(spa_pkg::CMD_LOAD_FIRST, MIN_COEF, 16'h8000);
    push_item(spa_pkg::CMD_LOAD_SECOND, MIN_COEF, 16'h8000);
    push_item(spa_pkg::CMD_LOAD_FIRST, 32'sd5, 16'd1000);
    push_item(spa_pkg::CMD_LOAD_SECOND, -32'sd5, 16'd1000);
    push_item(spa_pkg::CMD_LOAD_FIRST, -32'sd1, 16'd0);
    push_item(spa_pkg::CMD_ADD, '1, '1);
    // Tail copied from the second store, with an ignored command in between.
    push_item(spa_pkg::CMD_LOAD_FIRST, 32'sd3, 16'hFFFF);
    push_item(spa_pkg::CMD_LOAD_SECOND, 32'sd100, 16'd300);
    push_item(CMD_IGNORED, '0, '0);
    push_item(spa_pkg::CMD_LOAD_SECOND, MIN_COEF, 16'd0);
    push_item(spa_pkg::CMD_ADD, '0, '0);
    // Ascending loads: the merge follows the heads as they stand.
    push_item(spa_pkg::CMD_LOAD_FIRST, 32'sd10, 16'd10);
    push_item(spa_pkg::CMD_LOAD_FIRST, 32'sd20, 16'd20);
    push_item(spa_pkg::CMD_LOAD_SECOND, 32'sd15, 16'd15);
    push_item(spa_pkg::CMD_LOAD_SECOND, MAX_COEF, 16'd20);
    push_item(spa_pkg::CMD_ADD, '0, '0);
    // Only the second store holds a term.
    push_item(spa_pkg::CMD_LOAD_SECOND, 32'sh5555_AAAA, 16'h5AA5);
    push_item(spa_pkg::CMD_ADD, '0, '0);
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_terms.size() != 0)
      @(negedge clk);
  endtask

  // Stimulus sequence: directed items, a long receiver hold, then random phases.
  initial begin : stimulus
    int idle_plan [5][2];
    idle_plan = '{'{0, 0}, '{86, 0}, '{0, 86}, '{13, 13}, '{0, 0}};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    queue_directed_items();
    wait_drained();

    // Overfill the first store and hold the output so the block backs up its input.
    queue_merge_case(spa_pkg::MAX_TERMS + 2, 4);
    queue_merge_case(6, 6);
    holds_asked = holds_asked + 1;
    wait_drained();

    for (int m = 0; m < 5; m++) begin
      sender_idle_pct = idle_plan[m][0];
      recv_stall_pct  = idle_plan[m][1];
      queue_random_items(CHUNK_ITEMS);
      wait_drained();
    end

    repeat (END_PAUSE) @(negedge clk);
    if (mismatches == 0 && expected_terms.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/spa_pkg.sv
src/spa_term_store.sv
src/spa_merge_unit.sv
src/sparse_polynomial_adder.sv
dv/tb_sparse_polynomial_adder.sv
